// ===== rtl/rgw_pkg.sv =====
package rgw_pkg;

   localparam int U_W    = 10;
   localparam int P_W    = 13;
   localparam int POS_W  = 48;
   localparam int OP_W   = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 80;

   localparam logic [9:0]  UNDERSHOOT_RST = 10'd0;
   localparam logic [12:0] PIXELS_RST     = 13'd512;
   localparam logic [12:0] LINES_RST      = 13'd512;
   localparam logic [30:0] STEP_RST       = 31'd32768;
   localparam logic [63:0] MATRIX_RST     = 64'h4000_0000_0000_4000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DRAIN
   } state_type;

   typedef enum logic [2:0] {
      CSR_UNDERSHOOT = 3'd0,
      CSR_PIXELS     = 3'd1,
      CSR_LINES      = 3'd2,
      CSR_X_START    = 3'd3,
      CSR_Y_START    = 3'd4,
      CSR_STEP       = 3'd5,
      CSR_MATRIX     = 3'd6,
      CSR_OFFSET     = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      SP_JS, SP_XB, SP_TT, SP_H, SP_K, SP_KLO, SP_KHI, SP_YLO, SP_YHI,
      SP_M0L, SP_M0H, SP_M1L, SP_M1H, SP_XO, SP_M2H, SP_M3L, SP_M3H, SP_YO
   } step_type;

   typedef struct packed {
      logic retrace;
      logic last_line;
      logic line_clock;
      logic flim_line_clock;
      logic flim_frame_clock;
      logic frame_end;
   } flags_type;

   function automatic logic [31:0] round_sat(input logic signed [ACC_W-1:0] acc,
                                             input logic signed [31:0] off);
      logic signed [ACC_W-1:0] r;
      r = (acc + ACC_W'(8192)) >>> 14;
      r = r + ACC_W'(off);
      if (r > ACC_W'(64'sd2147483647)) begin
         return 32'h7FFF_FFFF;
      end else if (r < ACC_W'(-64'sd2147483648)) begin
         return 32'h8000_0000;
      end
      return r[31:0];
   endfunction

endpackage

// ===== rtl/rgw_mul.sv =====
module rgw_mul (
   input  logic                                clock,
   input  logic signed [rgw_pkg::OP_W-1:0]     op_a,
   input  logic signed [rgw_pkg::OP_W-1:0]     op_b,
   output logic signed [rgw_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [rgw_pkg::PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/rgw_geom.sv =====
module rgw_geom #(
   parameter int RETRACE_LEN    = 128,
   parameter int MAX_PIXELS     = 4096,
   parameter int MAX_LINES      = 4096,
   parameter int MAX_UNDERSHOOT = 1024,
   parameter int LW             = 13,
   parameter int JW             = 12,
   parameter int TW             = 7
) (
   input  logic                    restart,
   input  logic [LW-1:0]           i_cur,
   input  logic [JW-1:0]           j_cur,
   input  logic [rgw_pkg::U_W-1:0] undershoot,
   input  logic [rgw_pkg::P_W-1:0] pixels,
   input  logic [rgw_pkg::P_W-1:0] lines,
   output logic [LW-1:0]           idx,
   output logic [JW-1:0]           line,
   output logic [rgw_pkg::U_W-1:0] u_c,
   output logic [rgw_pkg::P_W-1:0] p_c,
   output logic [LW-1:0]           len,
   output logic [TW-1:0]           t,
   output logic [LW-1:0]           next_i,
   output logic [JW-1:0]           next_j,
   output rgw_pkg::flags_type      flags
);

   logic [rgw_pkg::P_W-1:0] n_c;
   logic [LW-1:0]           te;
   logic [LW-1:0]           i0;
   logic [JW-1:0]           j0;
   logic [LW-1:0]           tdiff;
   logic                    last;

   always_comb begin
      u_c = (int'(undershoot) > MAX_UNDERSHOOT) ? rgw_pkg::U_W'(MAX_UNDERSHOOT) : undershoot;
      if (pixels == '0) begin
         p_c = rgw_pkg::P_W'(1);
      end else if (int'(pixels) > MAX_PIXELS) begin
         p_c = rgw_pkg::P_W'(MAX_PIXELS);
      end else begin
         p_c = pixels;
      end
      if (lines == '0) begin
         n_c = rgw_pkg::P_W'(1);
      end else if (int'(lines) > MAX_LINES) begin
         n_c = rgw_pkg::P_W'(MAX_LINES);
      end else begin
         n_c = lines;
      end
      te  = LW'(u_c) + LW'(p_c);
      len = te + LW'(RETRACE_LEN);
      i0  = restart ? '0 : i_cur;
      j0  = restart ? '0 : j_cur;
      line = (14'(j0) >= 14'(n_c)) ? '0 : j0;
      idx  = (i0 >= len) ? '0 : i0;
      tdiff = idx - te;
      t     = tdiff[TW-1:0];
      last  = (14'(line) == (14'(n_c) - 14'd1));
      if (idx == (len - LW'(1))) begin
         next_i = '0;
         next_j = last ? '0 : line + JW'(1);
      end else begin
         next_i = idx + LW'(1);
         next_j = line;
      end
      flags.retrace          = (idx >= te);
      flags.last_line        = last;
      flags.line_clock       = (idx >= LW'(u_c)) && (idx < te);
      flags.flim_line_clock  = (idx >= te);
      flags.flim_frame_clock = last && (idx > te);
      flags.frame_end        = last && (idx == (len - LW'(1)));
   end

endmodule

// ===== rtl/raster_galvo_waveform_generator.sv =====
// Each accepted request runs ST_CALC, then ST_DRAIN registers the result and rsp_tvalid.
// A new sample waits until the last is done; req_tready is high only between samples.
// Each sample runs 18 passes through one shared 33x33 multiplier, one pass per cycle.
// A result waits in the output register until taken while the next sample is accepted.
// Synchronous reset clears counters and the sequencer and loads register defaults.
module raster_galvo_waveform_generator #(
   parameter int RETRACE_LEN    = 128,
   parameter int MAX_PIXELS     = 4096,
   parameter int MAX_LINES      = 4096,
   parameter int MAX_UNDERSHOOT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] x_out, [63:32] y_out, [64] line_clock,
                                    // [65] flim_line_clock, [66] flim_frame_clock
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   localparam int PMAX = (MAX_PIXELS < 8191) ? MAX_PIXELS : 8191;
   localparam int LMAX = (MAX_LINES < 8191) ? MAX_LINES : 8191;
   localparam int LW   = $clog2(1024 + PMAX + RETRACE_LEN);
   localparam int JW   = $clog2(LMAX);
   localparam int TW   = $clog2(RETRACE_LEN);
   localparam int KB   = $clog2(RETRACE_LEN + 1) - 1;
   localparam int SH   = 3 * KB;
   localparam int HW   = 3 * TW;
   localparam int AW   = rgw_pkg::ACC_W;
   localparam int PW   = rgw_pkg::POS_W;
   localparam int OW   = rgw_pkg::OP_W;

   logic [9:0]  undershoot_ff;
   logic [12:0] pixels_ff;
   logic [12:0] lines_ff;
   logic [31:0] x_start_ff;
   logic [31:0] y_start_ff;
   logic [30:0] scan_step_ff;
   logic [63:0] matrix_ff;
   logic [63:0] offset_ff;

   rgw_pkg::state_type state_ff, state_in;
   rgw_pkg::step_type  seq_ff, seq_in;
   logic [LW-1:0]      i_ff;
   logic [JW-1:0]      j_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load_out;
   logic               accept;

   logic [LW-1:0]           g_idx, g_len, g_next_i;
   logic [JW-1:0]           g_line, g_next_j;
   logic [rgw_pkg::U_W-1:0] g_u;
   logic [rgw_pkg::P_W-1:0] g_p;
   logic [TW-1:0]           g_t;
   rgw_pkg::flags_type      g_flags;

   logic [LW-1:0]           idx_ff, len_ff;
   logic [JW-1:0]           line_ff;
   logic [rgw_pkg::U_W-1:0] u_ff;
   logic [rgw_pkg::P_W-1:0] p_ff;
   logic [TW-1:0]           t_ff;
   rgw_pkg::flags_type      flags_ff;

   logic signed [PW-1:0]    level_ff, xb_ff, x_ff, y_ff;
   logic [PW-1:0]           js_ff, k_ff;
   logic [HW-1:0]           h_ff;
   logic signed [AW-1:0]    acc_ff;
   logic [31:0]             xo_ff, yo_ff;
   logic [71:0]             rsp_data_ff;
   logic                    rsp_last_ff;

   logic signed [OW-1:0]            op_a, op_b;
   logic signed [rgw_pkg::PROD_W-1:0] prod_ff;
   logic signed [AW-1:0]            prod_ext, prod_hi, sum_hi, spl;
   logic signed [PW-1:0]            rspl;
   logic signed [LW:0]              iu_diff;
   logic [LW-1:0]                   pt_sum;
   logic [PW-1:0]                   my_val;
   logic [31:0]                     mat_res;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == rgw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         undershoot_ff <= rgw_pkg::UNDERSHOOT_RST;
         pixels_ff     <= rgw_pkg::PIXELS_RST;
         lines_ff      <= rgw_pkg::LINES_RST;
         x_start_ff    <= '0;
         y_start_ff    <= '0;
         scan_step_ff  <= rgw_pkg::STEP_RST;
         matrix_ff     <= rgw_pkg::MATRIX_RST;
         offset_ff     <= '0;
      end else if (csr_we) begin
         case (rgw_pkg::csr_index_type'(csr_addr))
            rgw_pkg::CSR_UNDERSHOOT: undershoot_ff <= csr_wdata[9:0];
            rgw_pkg::CSR_PIXELS:     pixels_ff     <= csr_wdata[12:0];
            rgw_pkg::CSR_LINES:      lines_ff      <= csr_wdata[12:0];
            rgw_pkg::CSR_X_START:    x_start_ff    <= csr_wdata[31:0];
            rgw_pkg::CSR_Y_START:    y_start_ff    <= csr_wdata[31:0];
            rgw_pkg::CSR_STEP:       scan_step_ff  <= csr_wdata[30:0];
            rgw_pkg::CSR_MATRIX:     matrix_ff     <= csr_wdata;
            rgw_pkg::CSR_OFFSET:     offset_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   rgw_geom #(
      .RETRACE_LEN(RETRACE_LEN), .MAX_PIXELS(MAX_PIXELS), .MAX_LINES(MAX_LINES),
      .MAX_UNDERSHOOT(MAX_UNDERSHOOT), .LW(LW), .JW(JW), .TW(TW)
   ) u_geom (
      .restart(req_tdata[0]), .i_cur(i_ff), .j_cur(j_ff),
      .undershoot(undershoot_ff), .pixels(pixels_ff), .lines(lines_ff),
      .idx(g_idx), .line(g_line), .u_c(g_u), .p_c(g_p), .len(g_len), .t(g_t),
      .next_i(g_next_i), .next_j(g_next_j), .flags(g_flags)
   );

   rgw_mul u_mul (
      .clock(clock), .op_a(op_a), .op_b(op_b), .prod_ff(prod_ff)
   );

   always_comb begin
      state_in     = state_ff;
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      load_out     = 1'b0;
      case (state_ff)
         rgw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rgw_pkg::ST_CALC;
               seq_in   = rgw_pkg::SP_JS;
            end
         end
         rgw_pkg::ST_CALC: begin
            if (seq_ff == rgw_pkg::SP_YO) begin
               state_in = rgw_pkg::ST_DRAIN;
            end else begin
               seq_in = rgw_pkg::step_type'(seq_ff + 5'd1);
            end
         end
         rgw_pkg::ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rgw_pkg::ST_IDLE;
            end
         end
         default: state_in = rgw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgw_pkg::ST_IDLE;
         seq_ff       <= rgw_pkg::SP_JS;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            i_ff <= g_next_i;
            j_ff <= g_next_j;
         end
      end
   end

   always_comb begin
      prod_ext = AW'(prod_ff);
      prod_hi  = prod_ext <<< 32;
      sum_hi   = acc_ff + prod_hi;
      spl      = (sum_hi + (AW'(1) <<< (SH - 1))) >>> SH;
      rspl     = spl[PW-1:0];
      iu_diff  = $signed({1'b0, idx_ff}) - $signed({1'b0, LW'(u_ff)});
      pt_sum   = LW'(p_ff) + LW'(t_ff);
      my_val   = flags_ff.last_line ? js_ff : PW'(scan_step_ff);
      mat_res  = rgw_pkg::round_sat(sum_hi, $signed(offset_ff[31:0]));
      op_a     = '0;
      op_b     = '0;
      case (seq_ff)
         rgw_pkg::SP_JS: begin
            op_a = OW'(line_ff);
            op_b = OW'(scan_step_ff);
         end
         rgw_pkg::SP_XB: begin
            op_a = flags_ff.retrace ? OW'(pt_sum) : OW'(iu_diff);
            op_b = OW'(scan_step_ff);
         end
         rgw_pkg::SP_TT: begin
            op_a = OW'(t_ff);
            op_b = OW'(t_ff);
         end
         rgw_pkg::SP_H: begin
            op_a = OW'(prod_ff[2*TW-1:0]);
            op_b = OW'(3 * RETRACE_LEN) - OW'({t_ff, 1'b0});
         end
         rgw_pkg::SP_K: begin
            op_a = OW'(len_ff);
            op_b = OW'(prod_ff[HW-1:0]);
         end
         rgw_pkg::SP_KLO: begin
            op_a = {1'b0, prod_ff[31:0]};
            op_b = OW'(scan_step_ff);
         end
         rgw_pkg::SP_KHI: begin
            op_a = OW'(k_ff[PW-1:32]);
            op_b = OW'(scan_step_ff);
         end
         rgw_pkg::SP_YLO: begin
            op_a = {1'b0, my_val[31:0]};
            op_b = OW'(h_ff);
         end
         rgw_pkg::SP_YHI: begin
            op_a = OW'(my_val[PW-1:32]);
            op_b = OW'(h_ff);
         end
         rgw_pkg::SP_M0L: begin
            op_a = OW'($signed(matrix_ff[15:0]));
            op_b = {1'b0, x_ff[31:0]};
         end
         rgw_pkg::SP_M0H: begin
            op_a = OW'($signed(matrix_ff[15:0]));
            op_b = OW'($signed(x_ff[PW-1:32]));
         end
         rgw_pkg::SP_M1L: begin
            op_a = OW'($signed(matrix_ff[31:16]));
            op_b = {1'b0, y_ff[31:0]};
         end
         rgw_pkg::SP_M1H: begin
            op_a = OW'($signed(matrix_ff[31:16]));
            op_b = OW'($signed(y_ff[PW-1:32]));
         end
         rgw_pkg::SP_XO: begin
            op_a = OW'($signed(matrix_ff[47:32]));
            op_b = {1'b0, x_ff[31:0]};
         end
         rgw_pkg::SP_M2H: begin
            op_a = OW'($signed(matrix_ff[47:32]));
            op_b = OW'($signed(x_ff[PW-1:32]));
         end
         rgw_pkg::SP_M3L: begin
            op_a = OW'($signed(matrix_ff[63:48]));
            op_b = {1'b0, y_ff[31:0]};
         end
         rgw_pkg::SP_M3H: begin
            op_a = OW'($signed(matrix_ff[63:48]));
            op_b = OW'($signed(y_ff[PW-1:32]));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff   <= g_idx;
         len_ff   <= g_len;
         line_ff  <= g_line;
         u_ff     <= g_u;
         p_ff     <= g_p;
         t_ff     <= g_t;
         flags_ff <= g_flags;
      end else if (state_ff == rgw_pkg::ST_CALC) begin
         case (seq_ff)
            rgw_pkg::SP_XB: begin
               level_ff <= PW'($signed(y_start_ff)) + PW'(prod_ff);
               js_ff    <= prod_ff[PW-1:0];
            end
            rgw_pkg::SP_TT:  xb_ff <= PW'($signed(x_start_ff)) + PW'(prod_ff);
            rgw_pkg::SP_K:   h_ff  <= prod_ff[HW-1:0];
            rgw_pkg::SP_KLO: k_ff  <= prod_ff[PW-1:0];
            rgw_pkg::SP_KHI: acc_ff <= prod_ext;
            rgw_pkg::SP_YLO: x_ff <= flags_ff.retrace ? xb_ff - rspl : xb_ff;
            rgw_pkg::SP_YHI: acc_ff <= prod_ext;
            rgw_pkg::SP_M0L: begin
               if (!flags_ff.retrace) begin
                  y_ff <= level_ff;
               end else if (flags_ff.last_line) begin
                  y_ff <= level_ff - rspl;
               end else begin
                  y_ff <= level_ff + rspl;
               end
            end
            rgw_pkg::SP_M0H: acc_ff <= prod_ext;
            rgw_pkg::SP_M1L: acc_ff <= acc_ff + prod_hi;
            rgw_pkg::SP_M1H: acc_ff <= acc_ff + prod_ext;
            rgw_pkg::SP_XO:  xo_ff  <= mat_res;
            rgw_pkg::SP_M2H: acc_ff <= prod_ext;
            rgw_pkg::SP_M3L: acc_ff <= acc_ff + prod_hi;
            rgw_pkg::SP_M3H: acc_ff <= acc_ff + prod_ext;
            rgw_pkg::SP_YO:  yo_ff  <= rgw_pkg::round_sat(sum_hi, $signed(offset_ff[63:32]));
            default: ;
         endcase
      end
      if (load_out) begin
         rsp_data_ff <= {5'd0, flags_ff.flim_frame_clock, flags_ff.flim_line_clock,
                         flags_ff.line_clock, yo_ff, xo_ff};
         rsp_last_ff <= flags_ff.frame_end;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rgw_pkg::ST_CALC && seq_ff == rgw_pkg::SP_JS))
      else $error("sequencer did not start after accepted transaction");
   a_drain_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgw_pkg::ST_DRAIN && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == rgw_pkg::ST_DRAIN))
      else $error("result dropped while output stalled");
   a_clocks_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[64] && rsp_data_ff[65]))
      else $error("line clock and flim line clock both high");
   a_frame_in_retrace: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[66]) |-> rsp_data_ff[65])
      else $error("flim frame clock outside retrace");
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      int'(j_ff) < LMAX)
      else $error("line counter out of range");
`endif

endmodule

// ===== sim/raster_galvo_waveform_generator_test.sv =====
`timescale 1ns / 1ps

module raster_galvo_waveform_generator_test;

   localparam int RETRACE   = 128;
   localparam int SPL_SH    = 3 * $clog2(RETRACE);
   localparam int WDOG_MAX  = 5000;
   localparam int DRAIN_CYC = 40;

   typedef struct {
      logic [31:0] x_pos;
      logic [31:0] y_pos;
      logic        line_clk;
      logic        flim_line;
      logic        flim_frame;
      logic        frame_end;
   } sample_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   raster_galvo_waveform_generator DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // scan geometry and transform shadow
   int unsigned cfg_under, cfg_pixels, cfg_lines;
   longint      cfg_xs, cfg_ys, cfg_step;
   logic [63:0] cfg_matrix, cfg_offset;
   int unsigned pos_sample, pos_line;

   bit          restart_q[$];
   sample_type  samples_due[$];
   int          mismatches;
   int          samples_seen;
   int          frames_seen;
   int          wdog;
   int          req_gap;
   int          rsp_gap;
   bit          req_taken;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 11) == 0) return $urandom_range(15, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic longint hermite_term(longint e, longint t);
      logic [127:0] mag, h, r;
      logic [61:0]  r62;
      bit           neg;
      neg = e < 0;
      mag = neg ? 128'(-e) : 128'(e);
      h   = 128'(t * t * (3 * RETRACE - 2 * t));
      r   = (mag * h + (128'd1 << (SPL_SH - 1))) >> SPL_SH;
      r62 = r[61:0];
      return neg ? -longint'({2'b00, r62}) : longint'({2'b00, r62});
   endfunction

   function automatic longint round_q14(longint p);
      logic [63:0] u;
      u = 64'(p) + (64'd1 << 62) + (64'd1 << 13);
      return longint'({14'd0, u[63:14]}) - (longint'(1) << 48);
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic sample_type next_sample(bit restart);
      sample_type  r;
      int unsigned u, p, nl, te, len, i, j;
      longint      s, x, y, lvl, ex, ey, t, xo, yo, m0, m1, m2, m3;
      u  = (cfg_under > 1024) ? 1024 : cfg_under;
      p  = (cfg_pixels < 1) ? 1 : (cfg_pixels > 4096) ? 4096 : cfg_pixels;
      nl = (cfg_lines < 1) ? 1 : (cfg_lines > 4096) ? 4096 : cfg_lines;
      te  = u + p;
      len = te + RETRACE;
      if (restart) begin
         pos_sample = 0;
         pos_line   = 0;
      end
      if (pos_line >= nl) pos_line = 0;
      if (pos_sample >= len) pos_sample = 0;
      i = pos_sample;
      j = pos_line;
      s = cfg_step;
      lvl = cfg_ys + longint'(j) * s;
      if (i < te) begin
         x = cfg_xs + (longint'(i) - longint'(u)) * s;
         y = lvl;
      end else begin
         t  = longint'(i - te);
         ex = -longint'(te) * s - longint'(RETRACE) * s;
         ey = (j + 1 < nl) ? s : -longint'(j) * s;
         x  = cfg_xs + longint'(p) * s + s * t + hermite_term(ex, t);
         y  = lvl + hermite_term(ey, t);
      end
      m0 = longint'($signed(cfg_matrix[15:0]));
      m1 = longint'($signed(cfg_matrix[31:16]));
      m2 = longint'($signed(cfg_matrix[47:32]));
      m3 = longint'($signed(cfg_matrix[63:48]));
      xo = round_q14(m0 * x + m1 * y) + longint'($signed(cfg_offset[31:0]));
      yo = round_q14(m2 * x + m3 * y) + longint'($signed(cfg_offset[63:32]));
      r.x_pos      = clip32(xo);
      r.y_pos      = clip32(yo);
      r.line_clk   = (i >= u && i < te);
      r.flim_line  = (i >= te);
      r.flim_frame = (j == nl - 1 && i > te);
      r.frame_end  = (j == nl - 1 && i == len - 1);
      i++;
      if (i >= len) begin
         i = 0;
         j++;
         if (j >= nl) j = 0;
      end
      pos_sample = i;
      pos_line   = j;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (restart_q.size() > 0) begin
            req_tdata  <= {7'd0, restart_q[0]};
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      sample_type exp_s;
      bit         act;
      act = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         samples_due.push_back(next_sample(req_tdata[0]));
         void'(restart_q.pop_front());
         req_taken = 1'b1;
         act = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         act = 1'b1;
         samples_seen++;
         if (rsp_tlast) frames_seen++;
         if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp transaction: %h", rsp_tdata);
         end else begin
            exp_s = samples_due.pop_front();
            if (rsp_tdata[31:0] !== exp_s.x_pos || rsp_tdata[63:32] !== exp_s.y_pos ||
                rsp_tdata[64] !== exp_s.line_clk || rsp_tdata[65] !== exp_s.flim_line ||
                rsp_tdata[66] !== exp_s.flim_frame || rsp_tlast !== exp_s.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h flags=%b%b%b%b, got x=%h y=%h flags=%b%b%b%b",
                           exp_s.x_pos, exp_s.y_pos, exp_s.line_clk, exp_s.flim_line,
                           exp_s.flim_frame, exp_s.frame_end, rsp_tdata[31:0],
                           rsp_tdata[63:32], rsp_tdata[64], rsp_tdata[65], rsp_tdata[66],
                           rsp_tlast);
            end
         end
      end
      if (act || reset || csr_we) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(rgw_pkg::csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         rgw_pkg::CSR_UNDERSHOOT: cfg_under  = 32'(val[9:0]);
         rgw_pkg::CSR_PIXELS:     cfg_pixels = 32'(val[12:0]);
         rgw_pkg::CSR_LINES:      cfg_lines  = 32'(val[12:0]);
         rgw_pkg::CSR_X_START:    cfg_xs     = longint'($signed(val[31:0]));
         rgw_pkg::CSR_Y_START:    cfg_ys     = longint'($signed(val[31:0]));
         rgw_pkg::CSR_STEP:       cfg_step   = longint'({33'd0, val[30:0]});
         rgw_pkg::CSR_MATRIX:     cfg_matrix = val;
         rgw_pkg::CSR_OFFSET:     cfg_offset = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (restart_q.size() > 0 || samples_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic run_phase(int n, int restart_odds);
      repeat (n) restart_q.push_back($urandom_range(0, restart_odds - 1) == 0);
      wait_drained();
   endtask

   logic [63:0] rnd64;
   initial begin
      cfg_under = 0;  cfg_pixels = 512;  cfg_lines = 512;
      cfg_xs = 0;  cfg_ys = 0;  cfg_step = 32768;
      cfg_matrix = rgw_pkg::MATRIX_RST;  cfg_offset = 0;
      pos_sample = 0;  pos_line = 0;
      mismatches = 0;  samples_seen = 0;  frames_seen = 0;  wdog = 0;
      req_gap = 0;  rsp_gap = 0;  req_taken = 0;  no_idle = 0;
      req_tvalid = 0;  req_tdata = 0;  rsp_tready = 0;
      csr_we = 0;  csr_addr = rgw_pkg::CSR_UNDERSHOOT;  csr_wdata = 0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults, with restarts at the start and mid-line
      restart_q.push_back(1'b0);
      restart_q.push_back(1'b1);
      repeat (8) restart_q.push_back(1'b0);
      restart_q.push_back(1'b1);
      repeat (4) restart_q.push_back(1'b0);
      wait_drained();

      // minimal geometry with clamped zero counts, saturating extremes
      write_csr(rgw_pkg::CSR_UNDERSHOOT, 64'd0);
      write_csr(rgw_pkg::CSR_PIXELS, 64'd0);
      write_csr(rgw_pkg::CSR_LINES, 64'd0);
      write_csr(rgw_pkg::CSR_X_START, 64'h7FFF_FFFF);
      write_csr(rgw_pkg::CSR_Y_START, 64'h8000_0000);
      write_csr(rgw_pkg::CSR_STEP, 64'h7FFF_FFFF);
      write_csr(rgw_pkg::CSR_MATRIX, 64'h7FFF_8000_8000_7FFF);
      write_csr(rgw_pkg::CSR_OFFSET, 64'h8000_0000_7FFF_FFFF);
      run_phase(12, 1000);

      // oversize counts clamp; shrink leaves counters beyond geometry
      write_csr(rgw_pkg::CSR_UNDERSHOOT, 64'd1023);
      write_csr(rgw_pkg::CSR_PIXELS, 64'h1FFF);
      write_csr(rgw_pkg::CSR_LINES, 64'h1FFF);
      write_csr(rgw_pkg::CSR_STEP, 64'd0);
      write_csr(rgw_pkg::CSR_MATRIX, 64'd0);
      write_csr(rgw_pkg::CSR_OFFSET, 64'h1234_5678_9ABC_DEF0);
      run_phase(60, 1000);
      write_csr(rgw_pkg::CSR_UNDERSHOOT, 64'd2);
      write_csr(rgw_pkg::CSR_PIXELS, 64'd3);
      write_csr(rgw_pkg::CSR_LINES, 64'd1);
      write_csr(rgw_pkg::CSR_STEP, 64'd32768);
      write_csr(rgw_pkg::CSR_MATRIX, rgw_pkg::MATRIX_RST);
      write_csr(rgw_pkg::CSR_OFFSET, 64'd0);
      run_phase(300, 1000);

      for (int ph = 0; ph < 12; ph++) begin
         no_idle = (ph % 4 == 3);
         write_csr(rgw_pkg::CSR_UNDERSHOOT, 64'($urandom_range(0, 20)));
         write_csr(rgw_pkg::CSR_PIXELS, 64'($urandom_range(1, 24)));
         write_csr(rgw_pkg::CSR_LINES, 64'($urandom_range(1, 3)));
         write_csr(rgw_pkg::CSR_X_START, 64'($urandom));
         write_csr(rgw_pkg::CSR_Y_START, 64'($urandom));
         write_csr(rgw_pkg::CSR_STEP,
                   (ph % 3 == 0) ? 64'($urandom) : 64'($urandom_range(0, 1 << 20)));
         rnd64 = {$urandom, $urandom};
         write_csr(rgw_pkg::CSR_MATRIX, (ph % 2 == 0) ? rnd64 : rgw_pkg::MATRIX_RST);
         rnd64 = {$urandom, $urandom};
         write_csr(rgw_pkg::CSR_OFFSET,
                   (ph % 3 == 1) ? rnd64 : {32'($urandom_range(0, 1 << 24)),
                                            32'($urandom_range(0, 1 << 24))});
         run_phase(130, 60);
      end
      no_idle = 0;

      $display("covered %0d samples in %0d frames over directed and random geometries",
               samples_seen, frames_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && samples_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rgw_pkg.sv
rtl/rgw_mul.sv
rtl/rgw_geom.sv
rtl/raster_galvo_waveform_generator.sv
sim/raster_galvo_waveform_generator_test.sv
